/* rtl/core/tsds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_pkg
// Shared types, register map and reset values of the two-sided diffuse
// shader core.
// ----------------------------------------------------------------------------
package tsds_pkg;

    // Default width of one normal component.
    localparam int NORMAL_BITS_DEF = 16;

    // Fixed internal widths.
    localparam int MAG_W   = 15;   // normalised magnitude, top bit at 14
    localparam int LEN_W   = 32;   // floor(sqrt(S * 2^32))
    localparam int DOT_W   = 32;   // |n.L| after normalisation
    localparam int SUMSQ_W = 32;   // sum of squares after normalisation
    localparam int QUO_W   = 19;   // unclamped facing quotient
    localparam int FAC_W   = 17;   // clamped facing, 0 .. 65536
    localparam int FACT_W  = 34;   // shading factor, Q2.32

    localparam logic [FAC_W-1:0] FACING_ONE = 17'd65536;

    // APB register map (word index = paddr[4:2]).
    localparam int PADDR_W = 5;
    typedef enum logic [2:0] {
        REG_LIGHT_X  = 3'd0,
        REG_LIGHT_Y  = 3'd1,
        REG_LIGHT_Z  = 3'd2,
        REG_AMBIENT  = 3'd3,
        REG_DIFFUSE  = 3'd4
    } reg_idx_t;

    // Register reset values.
    localparam logic [15:0] LIGHT_X_RST = 16'd12571;
    localparam logic [15:0] LIGHT_Y_RST = 16'hC9B9;   // -13895
    localparam logic [15:0] LIGHT_Z_RST = 16'h96FC;   // -26884
    localparam logic [15:0] AMBIENT_RST = 16'd23593;
    localparam logic [15:0] DIFFUSE_RST = 16'd41943;

    // Colour and zero-normal flag travelling alongside the arithmetic.
    typedef struct packed {
        logic       zero;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } side_t;

endpackage

/* rtl/core/tsds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_front
// Normal scaling, dot product with the light and sum of squares, in five
// register stages.
// ----------------------------------------------------------------------------
module tsds_front #(
    parameter int NORMAL_BITS = tsds_pkg::NORMAL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [NORMAL_BITS-1:0] normal_x,
    input  logic signed [NORMAL_BITS-1:0] normal_y,
    input  logic signed [NORMAL_BITS-1:0] normal_z,
    input  tsds_pkg::side_t               in_side,
    input  logic [15:0]                   light_x,
    input  logic [15:0]                   light_y,
    input  logic [15:0]                   light_z,
    output logic                          out_valid,
    output logic [tsds_pkg::DOT_W-1:0]    out_dot,
    output logic [tsds_pkg::SUMSQ_W-1:0]  out_sumsq,
    output tsds_pkg::side_t               out_side
);
    import tsds_pkg::*;

    localparam int POS_W = $clog2(NORMAL_BITS);

    logic [NORMAL_BITS-1:0]   raw   [3];
    logic [NORMAL_BITS-1:0]   mag1_next [3];
    logic [NORMAL_BITS-1:0]   mag1_reg  [3];
    logic [2:0]               neg1_reg;
    side_t                    side1_reg;
    logic [NORMAL_BITS-1:0]   or_bits;
    logic [POS_W-1:0]         pos2_next;
    logic [POS_W-1:0]         pos2_reg;
    logic [NORMAL_BITS-1:0]   mag2_reg  [3];
    logic [2:0]               neg2_reg;
    side_t                    side2_reg;
    logic [MAG_W-1:0]         mag3_next [3];
    logic [NORMAL_BITS+13:0]  shifted   [3];
    logic [MAG_W-1:0]         mag3_reg  [3];
    logic signed [15:0]       comp3_reg [3];
    side_t                    side3_reg;
    logic signed [31:0]       prod4_reg [3];
    logic [29:0]              sq4_reg   [3];
    side_t                    side4_reg;
    logic signed [33:0]       dot_sum;
    logic [33:0]              dot_abs;
    logic [DOT_W-1:0]         dot5_reg;
    logic [SUMSQ_W-1:0]       sumsq5_reg;
    side_t                    side5_reg;
    logic [4:0]               valid_reg;
    logic signed [15:0]       light [3];

    assign raw[0]   = normal_x;
    assign raw[1]   = normal_y;
    assign raw[2]   = normal_z;
    assign light[0] = light_x;
    assign light[1] = light_y;
    assign light[2] = light_z;

    // Magnitude of each component; the most negative value fits unsigned.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag1_next[i] = raw[i][NORMAL_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
        end
    end

    // Position of the leading one over all three magnitudes.
    assign or_bits = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
    always_comb begin
        pos2_next = '0;
        for (int i = 0; i < NORMAL_BITS; i++) begin
            if (or_bits[i]) begin
                pos2_next = POS_W'(i);
            end
        end
    end

    // Move the leading one of the largest magnitude to bit 14.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i]   = {mag2_reg[i], 14'b0} >> pos2_reg;
            mag3_next[i] = shifted[i][MAG_W-1:0];
        end
    end

    // Sum of the three products and its magnitude.
    assign dot_sum = 34'(prod4_reg[0]) + 34'(prod4_reg[1]) + 34'(prod4_reg[2]);
    assign dot_abs = dot_sum[33] ? 34'(-dot_sum) : 34'(dot_sum);

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Data stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i]  <= mag1_next[i];
                neg1_reg[i]  <= raw[i][NORMAL_BITS-1];
                mag2_reg[i]  <= mag1_reg[i];
                neg2_reg[i]  <= neg1_reg[i];
                mag3_reg[i]  <= mag3_next[i];
                comp3_reg[i] <= neg2_reg[i] ? -$signed({1'b0, mag3_next[i]})
                                            : $signed({1'b0, mag3_next[i]});
                prod4_reg[i] <= comp3_reg[i] * light[i];
                sq4_reg[i]   <= mag3_reg[i] * mag3_reg[i];
            end
            side1_reg      <= in_side;
            pos2_reg       <= pos2_next;
            side2_reg      <= {(or_bits == '0), side1_reg.r, side1_reg.g,
                               side1_reg.b, side1_reg.a};
            side3_reg      <= side2_reg;
            side4_reg      <= side3_reg;
            dot5_reg       <= dot_abs[DOT_W-1:0];
            sumsq5_reg     <= SUMSQ_W'(32'(sq4_reg[0]) + 32'(sq4_reg[1])
                                       + 32'(sq4_reg[2]));
            side5_reg      <= side4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_dot   = dot5_reg;
    assign out_sumsq = sumsq5_reg;
    assign out_side  = side5_reg;

endmodule

/* rtl/core/tsds_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_sqrt
// Digit-by-digit square root of S * 2^32, one result bit per register stage
// (32 stages).
// ----------------------------------------------------------------------------
module tsds_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tsds_pkg::SUMSQ_W-1:0]  in_sumsq,
    input  logic [tsds_pkg::DOT_W-1:0]    in_dot,
    input  tsds_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [tsds_pkg::LEN_W-1:0]    out_len,
    output logic [tsds_pkg::DOT_W-1:0]    out_dot,
    output tsds_pkg::side_t               out_side
);
    import tsds_pkg::*;

    localparam int REM_W = LEN_W + 3;

    logic [REM_W-1:0]   rem_reg   [LEN_W];
    logic [LEN_W-1:0]   root_reg  [LEN_W];
    logic [SUMSQ_W-1:0] sumsq_reg [LEN_W];
    logic [DOT_W-1:0]   dot_reg   [LEN_W];
    side_t              side_reg  [LEN_W];
    logic [LEN_W-1:0]   valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[LEN_W-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < LEN_W; j++) begin : g_step
        logic [REM_W-1:0]   rem_in;
        logic [LEN_W-1:0]   root_in;
        logic [SUMSQ_W-1:0] sumsq_in;
        logic [DOT_W-1:0]   dot_in;
        side_t              side_in;
        logic [1:0]         pair;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;

        if (j == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign sumsq_in = in_sumsq;
            assign dot_in   = in_dot;
            assign side_in  = in_side;
        end else begin : g_next
            assign rem_in   = rem_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign sumsq_in = sumsq_reg[j-1];
            assign dot_in   = dot_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        // The radicand's low half is zero; only the upper half feeds digits.
        if (j < SUMSQ_W / 2) begin : g_pair
            assign pair = sumsq_in[SUMSQ_W-1-2*j -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[REM_W-3:0], pair};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_sh >= trial) begin
                    rem_reg[j]  <= rem_sh - trial;
                    root_reg[j] <= {root_in[LEN_W-2:0], 1'b1};
                end else begin
                    rem_reg[j]  <= rem_sh;
                    root_reg[j] <= {root_in[LEN_W-2:0], 1'b0};
                end
                sumsq_reg[j] <= sumsq_in;
                dot_reg[j]   <= dot_in;
                side_reg[j]  <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[LEN_W-1];
    assign out_len   = root_reg[LEN_W-1];
    assign out_dot   = dot_reg[LEN_W-1];
    assign out_side  = side_reg[LEN_W-1];

endmodule

/* rtl/core/tsds_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_div
// Restoring division of |n.L| * 2^17 by the normal length, one quotient bit
// per register stage (19 stages).
// ----------------------------------------------------------------------------
module tsds_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [tsds_pkg::LEN_W-1:0]  in_len,
    input  logic [tsds_pkg::DOT_W-1:0]  in_dot,
    input  tsds_pkg::side_t             in_side,
    output logic                        out_valid,
    output logic [tsds_pkg::QUO_W-1:0]  out_quo,
    output tsds_pkg::side_t             out_side
);
    import tsds_pkg::*;

    localparam int REM_W = LEN_W + 1;

    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [LEN_W-1:0] len_reg  [QUO_W];
    logic [DOT_W-1:0] dot_reg  [QUO_W];
    side_t            side_reg [QUO_W];
    logic [QUO_W-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [LEN_W-1:0] len_in;
        logic [DOT_W-1:0] dot_in;
        side_t            side_in;
        logic             nbit;
        logic [REM_W-1:0] rem_sh;

        // Quotient stays below 2^19, so the dividend's top part is below len.
        if (i == 0) begin : g_first
            assign rem_in  = REM_W'(in_dot[DOT_W-1:2]);
            assign quo_in  = '0;
            assign len_in  = in_len;
            assign dot_in  = in_dot;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign len_in  = len_reg[i-1];
            assign dot_in  = dot_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // Dividend bit 18-i: the two lowest dot bits, then the zero fraction.
        if (i < 2) begin : g_dot_bit
            assign nbit = dot_in[1-i];
        end else begin : g_zero_bit
            assign nbit = 1'b0;
        end

        assign rem_sh = {rem_in[REM_W-2:0], nbit};

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (rem_sh >= REM_W'(len_in)) begin
                    rem_reg[i] <= rem_sh - REM_W'(len_in);
                    quo_reg[i] <= {quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= rem_sh;
                    quo_reg[i] <= {quo_in[QUO_W-2:0], 1'b0};
                end
                len_reg[i]  <= len_in;
                dot_reg[i]  <= dot_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

/* rtl/core/tsds_colour.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_colour
// Clamps the facing term, forms the shading factor and scales the colour,
// with rounding and saturation, in three register stages.
// ----------------------------------------------------------------------------
module tsds_colour (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [tsds_pkg::QUO_W-1:0]  in_quo,
    input  tsds_pkg::side_t             in_side,
    input  logic [15:0]                 ambient_weight,
    input  logic [15:0]                 diffuse_weight,
    output logic                        out_valid,
    output logic [7:0]                  out_r,
    output logic [7:0]                  out_g,
    output logic [7:0]                  out_b,
    output logic [7:0]                  out_a
);
    import tsds_pkg::*;

    localparam int PROD_W = FACT_W + 8;

    logic [FAC_W-1:0]  facing;
    logic [FACT_W-1:0] fact1_reg;
    side_t             side1_reg;
    logic [PROD_W-1:0] prod2_reg [3];
    logic [7:0]        a2_reg;
    logic [7:0]        chan_in   [3];
    logic [PROD_W-1:0] rounded   [3];
    logic [7:0]        chan_next [3];
    logic [7:0]        chan3_reg [3];
    logic [7:0]        a3_reg;
    logic [2:0]        valid_reg;

    // A zero normal sees ambient light only; facing saturates at one.
    always_comb begin
        if (in_side.zero) begin
            facing = '0;
        end else if (in_quo > QUO_W'(FACING_ONE)) begin
            facing = FACING_ONE;
        end else begin
            facing = in_quo[FAC_W-1:0];
        end
    end

    assign chan_in[0] = side1_reg.r;
    assign chan_in[1] = side1_reg.g;
    assign chan_in[2] = side1_reg.b;

    // Round half up at bit 31 and saturate to 8 bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rounded[i] = (prod2_reg[i] + (PROD_W'(1) << 31)) >> 32;
            chan_next[i] = (rounded[i] > PROD_W'(255)) ? 8'd255 : rounded[i][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fact1_reg <= {2'b00, ambient_weight, 16'b0}
                         + FACT_W'(diffuse_weight * facing);
            side1_reg <= in_side;
            for (int i = 0; i < 3; i++) begin
                prod2_reg[i] <= PROD_W'(chan_in[i]) * PROD_W'(fact1_reg);
                chan3_reg[i] <= chan_next[i];
            end
            a2_reg <= side1_reg.a;
            a3_reg <= a2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_r     = chan3_reg[0];
    assign out_g     = chan3_reg[1];
    assign out_b     = chan3_reg[2];
    assign out_a     = a3_reg;

endmodule

/* rtl/core/two_sided_diffuse_shader_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_diffuse_shader_core
// Two-sided Lambert diffuse shading of an RGBA colour against a configured
// light direction.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one transaction per cycle while the output is not
// stalled: a signed surface normal of any length and an RGBA base colour.
// The m_ channel returns the shaded colour, one transaction for each input,
// in order. Alpha is copied. The pipeline has five stages of normal scaling
// and dot products, 32 square-root stages (one root bit each), 19 division
// stages (one quotient bit each) and three stages of factor and colour
// arithmetic. Throughput is one transaction per cycle without output stalls.
// The pipeline advances as a whole whenever the output register is empty or
// is being read; when the receiver stalls with a result waiting, s_ready
// drops and every stage holds its contents, so nothing is lost or repeated.
// The APB port writes the light vector and the two weights; registers are
// to be written only while the pipeline is empty. Reset empties the pipeline
// and restores the default light and weights.
// ----------------------------------------------------------------------------
module two_sided_diffuse_shader_core #(
    parameter int NORMAL_BITS = tsds_pkg::NORMAL_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tsds_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [NORMAL_BITS-1:0]   s_normal_x,
    input  logic signed [NORMAL_BITS-1:0]   s_normal_y,
    input  logic signed [NORMAL_BITS-1:0]   s_normal_z,
    input  logic [7:0]                      s_base_r,
    input  logic [7:0]                      s_base_g,
    input  logic [7:0]                      s_base_b,
    input  logic [7:0]                      s_base_a,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_shaded_r,
    output logic [7:0]                      m_shaded_g,
    output logic [7:0]                      m_shaded_b,
    output logic [7:0]                      m_shaded_a
);
    import tsds_pkg::*;

    logic [15:0]        light_x_reg;
    logic [15:0]        light_y_reg;
    logic [15:0]        light_z_reg;
    logic [15:0]        ambient_reg;
    logic [15:0]        diffuse_reg;
    reg_idx_t           reg_idx;
    logic               adv;
    side_t              in_side;
    logic               fr_valid;
    logic [DOT_W-1:0]   fr_dot;
    logic [SUMSQ_W-1:0] fr_sumsq;
    side_t              fr_side;
    logic               sq_valid;
    logic [LEN_W-1:0]   sq_len;
    logic [DOT_W-1:0]   sq_dot;
    side_t              sq_side;
    logic               dv_valid;
    logic [QUO_W-1:0]   dv_quo;
    side_t              dv_side;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg <= LIGHT_X_RST;
            light_y_reg <= LIGHT_Y_RST;
            light_z_reg <= LIGHT_Z_RST;
            ambient_reg <= AMBIENT_RST;
            diffuse_reg <= DIFFUSE_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_LIGHT_X: light_x_reg <= pwdata[15:0];
                REG_LIGHT_Y: light_y_reg <= pwdata[15:0];
                REG_LIGHT_Z: light_z_reg <= pwdata[15:0];
                REG_AMBIENT: ambient_reg <= pwdata[15:0];
                REG_DIFFUSE: diffuse_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_LIGHT_X: prdata = {16'b0, light_x_reg};
            REG_LIGHT_Y: prdata = {16'b0, light_y_reg};
            REG_LIGHT_Z: prdata = {16'b0, light_z_reg};
            REG_AMBIENT: prdata = {16'b0, ambient_reg};
            REG_DIFFUSE: prdata = {16'b0, diffuse_reg};
            default:     prdata = '0;
        endcase
    end

    // The whole pipeline moves when the output register can take a result.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    always_comb begin
        in_side.zero = 1'b0;
        in_side.r    = s_base_r;
        in_side.g    = s_base_g;
        in_side.b    = s_base_b;
        in_side.a    = s_base_a;
    end

    tsds_front #(
        .NORMAL_BITS (NORMAL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .normal_x  (s_normal_x),
        .normal_y  (s_normal_y),
        .normal_z  (s_normal_z),
        .in_side   (in_side),
        .light_x   (light_x_reg),
        .light_y   (light_y_reg),
        .light_z   (light_z_reg),
        .out_valid (fr_valid),
        .out_dot   (fr_dot),
        .out_sumsq (fr_sumsq),
        .out_side  (fr_side)
    );

    tsds_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_sumsq  (fr_sumsq),
        .in_dot    (fr_dot),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_dot   (sq_dot),
        .out_side  (sq_side)
    );

    tsds_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_len    (sq_len),
        .in_dot    (sq_dot),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    tsds_colour u_colour (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adv            (adv),
        .in_valid       (dv_valid),
        .in_quo         (dv_quo),
        .in_side        (dv_side),
        .ambient_weight (ambient_reg),
        .diffuse_weight (diffuse_reg),
        .out_valid      (m_valid),
        .out_r          (m_shaded_r),
        .out_g          (m_shaded_g),
        .out_b          (m_shaded_b),
        .out_a          (m_shaded_a)
    );

endmodule

/* rtl/core/tsds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsds_checker
// Port-level checks of the shader core's flow control, bound to the top
// level.
// ----------------------------------------------------------------------------
module tsds_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_shaded_r,
    input logic [7:0] m_shaded_a
);

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shaded_r) && $stable(m_shaded_a))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty output register never holds back the input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A stalled result stops the input side.
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted during output stall");

endmodule

bind two_sided_diffuse_shader_core tsds_checker u_tsds_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_shaded_r (m_shaded_r),
    .m_shaded_a (m_shaded_a)
);

/* sim/two_sided_diffuse_shader_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_diffuse_shader_core_checker
// Watches both channels and the register port of the shader core, works out
// the shaded colour of every accepted input transaction and compares it,
// field by field, with the results in order.
// ----------------------------------------------------------------------------
module two_sided_diffuse_shader_core_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [tsds_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [15:0]            s_normal_x,
    input  logic signed [15:0]            s_normal_y,
    input  logic signed [15:0]            s_normal_z,
    input  logic [7:0]                    s_base_r,
    input  logic [7:0]                    s_base_g,
    input  logic [7:0]                    s_base_b,
    input  logic [7:0]                    s_base_a,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_shaded_r,
    input  logic [7:0]                    m_shaded_g,
    input  logic [7:0]                    m_shaded_b,
    input  logic [7:0]                    m_shaded_a,
    output int                            failures,
    output int                            pending
);
    import tsds_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } colour_t;

    logic signed [15:0] light_q[3];
    logic [15:0]        ambient_q;
    logic [15:0]        diffuse_q;
    colour_t            shaded_fifo[$];

    assign pending = shaded_fifo.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bit_q;
        r = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > v) bit_q = bit_q >> 2;
        while (bit_q != 0) begin
            if (v >= r + bit_q) begin
                v = v - (r + bit_q);
                r = (r >> 1) + bit_q;
            end else begin
                r = r >> 1;
            end
            bit_q = bit_q >> 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [63:0] f);
        logic [63:0] v;
        v = (64'(c) * f + (64'd1 << 31)) >> 32;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Shaded colour of one input against the current light and weights.
    function automatic colour_t shade_colour(input logic signed [15:0] nx,
                                             input logic signed [15:0] ny,
                                             input logic signed [15:0] nz,
                                             input colour_t base);
        logic [63:0]        mag[3];
        logic               neg[3];
        logic [63:0]        peak;
        logic [63:0]        facing;
        logic [63:0]        sumsq;
        logic [63:0]        abs_dot;
        logic [63:0]        len;
        logic [63:0]        factor;
        longint             dot;
        logic signed [15:0] comp[3];
        colour_t            res;
        comp[0] = nx; comp[1] = ny; comp[2] = nz;
        peak = 0;
        facing = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comp[i][15];
            mag[i] = neg[i] ? 64'(17'h10000 - {1'b0, comp[i]}) & 64'hFFFF : 64'(comp[i]);
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak != 0) begin
            while (peak < (64'd1 << 14)) begin
                peak = peak << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            while (peak >= (64'd1 << 15)) begin
                peak = peak >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            dot = 0;
            sumsq = 0;
            for (int i = 0; i < 3; i++) begin
                dot += (neg[i] ? -longint'(mag[i]) : longint'(mag[i])) * longint'(light_q[i]);
                sumsq += mag[i] * mag[i];
            end
            abs_dot = (dot < 0) ? 64'(-dot) : 64'(dot);
            len = int_sqrt(sumsq << 32);
            facing = (abs_dot << 17) / len;
            if (facing > 65536) facing = 65536;
        end
        factor = (64'(ambient_q) << 16) + 64'(diffuse_q) * facing;
        res.r = scale_channel(base.r, factor);
        res.g = scale_channel(base.g, factor);
        res.b = scale_channel(base.b, factor);
        res.a = base.a;
        return res;
    endfunction

    // Follow register writes, predict on input and compare on output.
    always @(posedge aclk) begin
        colour_t got;
        colour_t want;
        if (!aresetn) begin
            light_q[0] <= LIGHT_X_RST;
            light_q[1] <= LIGHT_Y_RST;
            light_q[2] <= LIGHT_Z_RST;
            ambient_q  <= AMBIENT_RST;
            diffuse_q  <= DIFFUSE_RST;
            shaded_fifo.delete();
            failures   <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_LIGHT_X: light_q[0] <= pwdata[15:0];
                    REG_LIGHT_Y: light_q[1] <= pwdata[15:0];
                    REG_LIGHT_Z: light_q[2] <= pwdata[15:0];
                    REG_AMBIENT: ambient_q  <= pwdata[15:0];
                    REG_DIFFUSE: diffuse_q  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                shaded_fifo.push_back(shade_colour(s_normal_x, s_normal_y, s_normal_z,
                                                   {s_base_r, s_base_g, s_base_b, s_base_a}));
            end
            if (m_valid && m_ready) begin
                got = {m_shaded_r, m_shaded_g, m_shaded_b, m_shaded_a};
                if (shaded_fifo.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, got);
                    failures <= failures + 1;
                end else begin
                    want = shaded_fifo.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch rgba expected %h actual %h", $time, want, got);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

endmodule

/* sim/two_sided_diffuse_shader_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_diffuse_shader_core_test
// Drives directed and random normals and colours through the shader core
// under several light and weight settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module two_sided_diffuse_shader_core_test;
    import tsds_pkg::*;

    localparam int PIPE_DEPTH = 59;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [15:0]     s_normal_x = '0;
    logic signed [15:0]     s_normal_y = '0;
    logic signed [15:0]     s_normal_z = '0;
    logic [7:0]             s_base_r = '0;
    logic [7:0]             s_base_g = '0;
    logic [7:0]             s_base_b = '0;
    logic [7:0]             s_base_a = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_shaded_r;
    logic [7:0]             m_shaded_g;
    logic [7:0]             m_shaded_b;
    logic [7:0]             m_shaded_a;
    int                     failures;
    int                     pending;

    always #5 aclk = ~aclk;

    two_sided_diffuse_shader_core i_dut (.*);

    two_sided_diffuse_shader_core_checker i_checker (.*);

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side stalls at random, with stretches of constant readiness.
    initial begin
        int span;
        @(posedge aclk);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                span = $urandom_range(20, 80);
                m_ready <= 1'b1;
                repeat (span) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 2) != 0) ? 1'b1 : ($urandom_range(0, 9) == 0);
                if (!m_ready && gap_length() > 5) repeat (gap_length()) @(negedge aclk);
            end
        end
    end

    task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shading(input logic [15:0] lx, input logic [15:0] ly,
                               input logic [15:0] lz, input logic [15:0] amb,
                               input logic [15:0] dif);
        write_register(REG_LIGHT_X, lx);
        write_register(REG_LIGHT_Y, ly);
        write_register(REG_LIGHT_Z, lz);
        write_register(REG_AMBIENT, amb);
        write_register(REG_DIFFUSE, dif);
    endtask

    // Present one transaction and hold it until it is accepted.
    task automatic send_pixel(input logic [15:0] nx, input logic [15:0] ny,
                              input logic [15:0] nz, input logic [31:0] rgba,
                              input bit with_gap);
        int gap;
        gap = with_gap ? gap_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_normal_x <= nx;
        s_normal_y <= ny;
        s_normal_z <= nz;
        {s_base_r, s_base_g, s_base_b, s_base_a} <= rgba;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [15:0] random_component();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3)) - 16'd1;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        bit burst;
        for (int k = 0; k < count; k++) begin
            burst = ($urandom_range(0, 9) < 3);
            send_pixel(random_component(), random_component(), random_component(),
                       $urandom, !burst);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with reset settings: extremes, zero normal, axes.
        send_pixel(16'h0000, 16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 32'h00000000, 1'b0);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 32'hFF80017F, 1'b0);
        send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h01FEFFAA, 1'b0);
        send_pixel(16'h0001, 16'h0000, 16'h0000, 32'hFFFFFF55, 1'b0);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 32'h80808080, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h8000, 32'hC0C0C0C0, 1'b0);
        send_pixel(16'd12571, 16'hC9B9, 16'h96FC, 32'hFFFFFFFF, 1'b0);
        send_pixel(16'h3000, 16'hFF00, 16'h0010, 32'h12345678, 1'b0);
        drain_pipeline();

        // Facing clamp with an over-long light and saturation above one.
        set_shading(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 1'b0);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 32'h01020304, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 32'hFF7F0109, 1'b0);
        send_pixel(16'h0001, 16'h0001, 16'h0000, 32'h807F40AA, 1'b0);
        drain_pipeline();
        set_shading(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_pixel(16'h1234, 16'h8000, 16'h0007, 32'hFFFFFFFF, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 32'hFFFFFF00, 1'b0);
        drain_pipeline();
        random_phase(120);
        drain_pipeline();

        // Random phases with the sender pausing between settings.
        for (int phase = 0; phase < 5; phase++) begin
            set_shading(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
            random_phase(110);
            drain_pipeline();
        end
        set_shading(LIGHT_X_RST, LIGHT_Y_RST, LIGHT_Z_RST, AMBIENT_RST, DIFFUSE_RST);
        random_phase(80);
        drain_pipeline();

        repeat (PIPE_DEPTH + 10) @(negedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("two_sided_diffuse_shader_core_test OK");
        end else begin
            $display("two_sided_diffuse_shader_core_test NOT OK");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("two_sided_diffuse_shader_core_test NOT OK");
        $finish;
    end

endmodule

/* two_sided_diffuse_shader_core.f */
rtl/core/tsds_pkg.sv
rtl/core/tsds_front.sv
rtl/core/tsds_sqrt.sv
rtl/core/tsds_div.sv
rtl/core/tsds_colour.sv
rtl/core/two_sided_diffuse_shader_core.sv
rtl/core/tsds_checker.sv
sim/two_sided_diffuse_shader_core_checker.sv
sim/two_sided_diffuse_shader_core_test.sv
